>>> rtl/core/lruc_pkg.sv
`timescale 1ns / 1ps

package lruc_pkg;

    // directory size and field widths
    localparam int ENTRIES = 8;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef logic [KEY_W-1:0]                 t_key;
    typedef logic [CNT_W-1:0]                 t_cnt;
    typedef logic [CAP_W-1:0]                 t_cap;
    typedef logic [OCC_W-1:0]                 t_occ;
    typedef logic [IDX_W-1:0]                 t_idx;
    typedef logic [RANK_W-1:0]                t_rank;
    typedef logic [ENTRIES-1:0]               t_vld_vec;
    typedef logic [ENTRIES-1:0][KEY_W-1:0]    t_key_arr;
    typedef logic [ENTRIES-1:0][RANK_W-1:0]   t_rank_arr;

    // tag compare and slot search results for one access
    typedef struct packed {
        logic  hit;
        t_idx  hit_idx;
        t_rank hit_rank;
        logic  free_found;
        t_idx  free_idx;
        t_idx  victim_idx;
    } t_lookup;

endpackage

>>> rtl/core/lruc_in_if.sv
`timescale 1ns / 1ps

interface lruc_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

>>> rtl/core/lruc_out_if.sv
`timescale 1ns / 1ps

interface lruc_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic               evicted_valid;
    logic [31:0]        evicted_key;
    logic [31:0]        hits_total;
    logic [31:0]        misses_total;

    modport source (output valid, output hit, output evicted_valid, output evicted_key,
                    output hits_total, output misses_total, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
                    input hits_total, input misses_total, output ready);
endinterface

>>> rtl/core/lruc_cfg_if.sv
`timescale 1ns / 1ps

interface lruc_cfg_if;
    logic               valid;
    logic               ready;
    logic [3:0]         data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/lruc_match.sv
`timescale 1ns / 1ps

module lruc_match (
    input  lruc_pkg::t_key      i_key,
    input  lruc_pkg::t_key_arr  i_keys,
    input  lruc_pkg::t_vld_vec  i_valid,
    input  lruc_pkg::t_rank_arr i_ranks,
    input  lruc_pkg::t_occ      i_occ,
    output lruc_pkg::t_lookup   o_lookup
);
    import lruc_pkg::*;

    t_rank w_oldest_rank;

    // oldest valid entry holds rank occupancy-1
    assign w_oldest_rank = RANK_W'(i_occ - t_occ'(1));

    // parallel tag compare, first free slot, victim search
    always_comb begin
        o_lookup = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!o_lookup.hit && i_valid[i] && (i_keys[i] == i_key)) begin
                o_lookup.hit      = 1'b1;
                o_lookup.hit_idx  = IDX_W'(i);
                o_lookup.hit_rank = i_ranks[i];
            end
            if (!o_lookup.free_found && !i_valid[i]) begin
                o_lookup.free_found = 1'b1;
                o_lookup.free_idx   = IDX_W'(i);
            end
            if (i_valid[i] && (i_ranks[i] == w_oldest_rank)) begin
                o_lookup.victim_idx = IDX_W'(i);
            end
        end
    end

endmodule

>>> rtl/core/lruc_dir.sv
`timescale 1ns / 1ps

module lruc_dir (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_upd,
    input  lruc_pkg::t_key i_key,
    input  lruc_pkg::t_occ i_limit,
    output logic           o_hit,
    output logic           o_evict,
    output lruc_pkg::t_key o_evicted_key,
    output logic           o_empty
);
    import lruc_pkg::*;

    t_key_arr  r_keys;
    t_vld_vec  r_valid;
    t_rank_arr r_rank;
    t_occ      r_occ;

    t_vld_vec  n_valid;
    t_rank_arr n_rank;
    t_occ      n_occ;
    t_lookup   w_lk;
    logic      w_full;
    t_idx      w_slot;

    lruc_match u_match (
        .i_key    (i_key),
        .i_keys   (r_keys),
        .i_valid  (r_valid),
        .i_ranks  (r_rank),
        .i_occ    (r_occ),
        .o_lookup (w_lk)
    );

    assign w_full        = !(r_occ < i_limit);
    assign w_slot        = w_full ? w_lk.victim_idx : w_lk.free_idx;
    assign o_hit         = w_lk.hit;
    assign o_evict       = !w_lk.hit && w_full;
    assign o_evicted_key = o_evict ? r_keys[w_lk.victim_idx] : '0;
    assign o_empty       = (r_occ == '0);

    // rank update: on a hit age younger entries, on a miss age all and insert
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        if (w_lk.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < w_lk.hit_rank)) begin
                    n_rank[i] = r_rank[i] + t_rank'(1);
                end
            end
            n_rank[w_lk.hit_idx] = '0;
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + t_rank'(1);
                end
            end
            n_rank[w_slot]  = '0;
            n_valid[w_slot] = 1'b1;
            if (!w_full) begin
                n_occ = r_occ + t_occ'(1);
            end
        end
    end

    // key store, written on a miss
    always_ff @(posedge i_clk) begin
        if (i_upd && !w_lk.hit) begin
            r_keys[w_slot] <= i_key;
        end
    end

    // directory control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_occ   <= '0;
        end else if (i_upd) begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_occ   <= n_occ;
        end
    end

endmodule

>>> rtl/core/lru_cache_tracker_core.sv
`timescale 1ns / 1ps

// path: an accepted input is held in the input register, which feeds the directory update;
// the update loads the result register once that register is free or being drained
// throughput: one access per cycle while o_out.ready drains the result register; lookup is combinational
// reset: synchronous active low; clears directory valid bits, ranks, occupancy and counters,
// capacity returns to 8
module lru_cache_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lruc_in_if.sink     i_in,
    lruc_cfg_if.sink    i_cfg,
    lruc_out_if.source  o_out
);
    import lruc_pkg::*;

    logic  r_in_valid;
    t_key  r_in_key;
    t_cap  r_cap;
    t_cnt  r_hits;
    t_cnt  r_misses;
    logic  r_out_valid;
    logic  r_out_hit;
    logic  r_out_evict;
    t_key  r_out_evicted_key;

    t_cnt  n_hits;
    t_cnt  n_misses;
    logic  w_adv;
    t_occ  w_limit;
    logic  w_hit;
    logic  w_evict;
    t_key  w_evicted_key;
    logic  w_empty;

    // process when the result register is free or being drained
    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    // capacity clamped to 1..ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            w_limit = t_occ'(1);
        end else if (32'(r_cap) > ENTRIES) begin
            w_limit = t_occ'(ENTRIES);
        end else begin
            w_limit = t_occ'(r_cap);
        end
    end

    lruc_dir u_dir (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (w_adv),
        .i_key         (r_in_key),
        .i_limit       (w_limit),
        .o_hit         (w_hit),
        .o_evict       (w_evict),
        .o_evicted_key (w_evicted_key),
        .o_empty       (w_empty)
    );

    // saturating counters
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (w_hit) begin
            if (r_hits != CNT_MAX) begin
                n_hits = r_hits + t_cnt'(1);
            end
        end else begin
            if (r_misses != CNT_MAX) begin
                n_misses = r_misses + t_cnt'(1);
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_key <= i_in.key;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_hit         <= w_hit;
            r_out_evict       <= w_evict;
            r_out_evicted_key <= w_evicted_key;
        end
    end

    // control state, counters and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_cap       <= CAP_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // capacity transfer only takes effect while the directory is empty
            if (i_cfg.valid && w_empty) begin
                r_cap <= i_cfg.data;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.evicted_valid = r_out_evict;
    assign o_out.evicted_key   = r_out_evicted_key;
    assign o_out.hits_total    = r_hits;
    assign o_out.misses_total  = r_misses;

endmodule
